/* sv/assert_macros.svh */
// Assertion macros shared by the snpzd modules.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside of reset.
`define SNPZD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SNPZD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/snpzd_pkg.sv */
// Package for the SNP zygosity distance core: field widths, register indexes,
// the configuration struct and the chunk popcount function. No dependencies.
package snpzd_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned DistW    = 32;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PopW     = 7;

  localparam logic [DistW-1:0] DistMax = '1;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_DIPLOID_MODE = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MISS_SAME    = 8'd1;

  // Current compare settings, handed from the register file to the front end.
  typedef struct packed {
    logic diploid_mode;
    logic miss_same;
  } cfg_t;

  // Number of set bits in a 64-bit chunk, summed as a six-level adder tree.
  function automatic logic [PopW-1:0] popcount64(input logic [DataW-1:0] v);
    logic [PopW-1:0] s [DataW];
    for (int i = 0; i < DataW; i++) begin
      s[i] = {{(PopW-1){1'b0}}, v[i]};
    end
    for (int lvl = 0; lvl < 6; lvl++) begin
      for (int i = 0; i < (32 >> lvl); i++) begin
        s[i] = s[2*i] + s[2*i+1];
      end
    end
    return s[0];
  endfunction

endpackage

/* sv/snp_zygosity_distance_core.sv */
// Top level of the SNP zygosity distance core: configuration registers,
// front end, chunk queue, back end and result queue. Depends on snpzd_pkg.
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+------------------------------------
//  chunk in | push / full                 | six 64-bit site fields, last_chunk_i
//  result   | empty / pop                 | pair_distance_o (32 bits)
//  config   | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i (bit 0 used)
//
// One chunk is taken every clock cycle unless the front end is stalled by a full
// chunk queue; classification with popcount takes one register stage and the
// accumulate takes another. A last chunk's distance passes through the front
// register and the chunk queue, and the back end pushes it straight into the
// result queue, from which it reaches the result ports.
// Reset sets both mode registers to 1 and clears the running distance.
// A full result queue stalls only last chunks in the back end; the two-entry
// chunk queue keeps the front end accepting meanwhile, until it fills.
module snp_zygosity_distance_core #(
  parameter int unsigned CHUNK_BITS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [snpzd_pkg::DataW-1:0]        first_sample_chrom_a_i,
  input  logic [snpzd_pkg::DataW-1:0]        first_sample_chrom_b_i,
  input  logic [snpzd_pkg::DataW-1:0]        second_sample_chrom_a_i,
  input  logic [snpzd_pkg::DataW-1:0]        second_sample_chrom_b_i,
  input  logic [snpzd_pkg::DataW-1:0]        first_missing_mask_i,
  input  logic [snpzd_pkg::DataW-1:0]        second_missing_mask_i,
  input  logic                               last_chunk_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [snpzd_pkg::DistW-1:0]        pair_distance_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [snpzd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [snpzd_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned CntW = $clog2(CHUNK_BITS + 1);

  snpzd_pkg::cfg_t             cfg_q, cfg_d;
  logic                        front_ready;
  logic                        f_valid, f_last, q_full;
  logic [CntW-1:0]             f_cnt;
  logic                        q_empty, q_pop;
  logic [CntW:0]               q_rdata;
  logic                        res_push, res_full;
  logic [snpzd_pkg::DistW-1:0] res_dist;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        snpzd_pkg::CFG_DIPLOID_MODE: cfg_d.diploid_mode = cfg_data_i[0];
        snpzd_pkg::CFG_MISS_SAME:    cfg_d.miss_same    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.diploid_mode <= 1'b1;
      cfg_q.miss_same    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: site classification and chunk count.
  assign full = !front_ready;

  snpzd_front #(
    .CHUNK_BITS(CHUNK_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (push),
    .in_ready_o  (front_ready),
    .p1_i        (first_sample_chrom_a_i),
    .p2_i        (first_sample_chrom_b_i),
    .q1_i        (second_sample_chrom_a_i),
    .q2_i        (second_sample_chrom_b_i),
    .miss1_i     (first_missing_mask_i),
    .miss2_i     (second_missing_mask_i),
    .last_i      (last_chunk_i),
    .out_valid_o (f_valid),
    .out_ready_i (!q_full),
    .out_cnt_o   (f_cnt),
    .out_last_o  (f_last)
  );

  // Chunk queue between the two halves.
  snpzd_fifo #(
    .Width(CntW + 1),
    .Depth(2)
  ) u_chunk_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .full_o  (q_full),
    .wdata_i ({f_last, f_cnt}),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  // Back end: saturating accumulation per sample pair.
  snpzd_back #(
    .CHUNK_BITS(CHUNK_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!q_empty),
    .in_pop_o   (q_pop),
    .in_cnt_i   (q_rdata[CntW-1:0]),
    .in_last_i  (q_rdata[CntW]),
    .res_push_o (res_push),
    .res_full_i (res_full),
    .res_dist_o (res_dist)
  );

  // Result queue feeding the output ports.
  snpzd_fifo #(
    .Width(snpzd_pkg::DistW),
    .Depth(2)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res_dist),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (pair_distance_o)
  );

endmodule

/* sv/snpzd_fifo.sv */
// Small flip-flop queue with push/full and pop/empty handshakes.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module snpzd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `SNPZD_ASSERT(a_fifo_cnt_bound, cnt_q <= FullCnt, "queue count above depth")
  `SNPZD_ASSERT_NEXT(a_fifo_cnt_up, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow on push")

endmodule

/* sv/snpzd_front.sv */
// Front end: classifies each site of a chunk, counts the differing sites
// and registers the count. Depends on snpzd_pkg.
module snpzd_front #(
  parameter int unsigned CHUNK_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  snpzd_pkg::cfg_t                  cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [snpzd_pkg::DataW-1:0]      p1_i,
  input  logic [snpzd_pkg::DataW-1:0]      p2_i,
  input  logic [snpzd_pkg::DataW-1:0]      q1_i,
  input  logic [snpzd_pkg::DataW-1:0]      q2_i,
  input  logic [snpzd_pkg::DataW-1:0]      miss1_i,
  input  logic [snpzd_pkg::DataW-1:0]      miss2_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [$clog2(CHUNK_BITS+1)-1:0]  out_cnt_o,
  output logic                             out_last_o
);

  localparam int unsigned CntW = $clog2(CHUNK_BITS + 1);
  localparam logic [snpzd_pkg::DataW-1:0] SiteMask =
      (CHUNK_BITS >= snpzd_pkg::DataW) ? '1
                                       : ((64'd1 << CHUNK_BITS) - 64'd1);

  logic [snpzd_pkg::DataW-1:0] hap_same, het, dom, rec, dip_same;
  logic [snpzd_pkg::DataW-1:0] same, missing, same_m, differ;
  logic [snpzd_pkg::PopW-1:0]  pop;
  logic                        valid_q, valid_d;
  logic [CntW-1:0]             cnt_q;
  logic                        last_q;
  logic                        take;

  // Site agreement in both modes, then the missing-site override.
  always_comb begin
    hap_same = ~(p1_i ^ q1_i);
    het      = (p1_i ^ p2_i) & (q1_i ^ q2_i);
    dom      = (p1_i & p2_i) & (q1_i & q2_i);
    rec      = ~(p1_i | p2_i) & ~(q1_i | q2_i);
    dip_same = het | dom | rec;
    same     = cfg_i.diploid_mode ? dip_same : hap_same;
    missing  = miss1_i | miss2_i;
    same_m   = cfg_i.miss_same ? (same | missing) : (same & ~missing);
    differ   = ~same_m & SiteMask;
    pop      = snpzd_pkg::popcount64(differ);
  end

  // Output stage register; it refills in the same cycle it drains.
  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cnt_q  <= pop[CntW-1:0];
      last_q <= last_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_cnt_o   = cnt_q;
  assign out_last_o  = last_q;

endmodule

/* sv/snpzd_back.sv */
// Back end: adds chunk counts into the saturating running distance and
// hands the total to the result queue on the last chunk. Depends on snpzd_pkg.
`include "assert_macros.svh"

module snpzd_back #(
  parameter int unsigned CHUNK_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_pop_o,
  input  logic [$clog2(CHUNK_BITS+1)-1:0]  in_cnt_i,
  input  logic                             in_last_i,
  output logic                             res_push_o,
  input  logic                             res_full_i,
  output logic [snpzd_pkg::DistW-1:0]      res_dist_o
);

  logic [snpzd_pkg::DistW-1:0] acc_q, acc_d;
  logic [snpzd_pkg::DistW:0]   sum;
  logic [snpzd_pkg::DistW-1:0] sat;
  logic                        consume, end_pair;

  // Saturating add of the chunk count.
  assign sum = {1'b0, acc_q} + (snpzd_pkg::DistW+1)'(in_cnt_i);
  assign sat = sum[snpzd_pkg::DistW] ? snpzd_pkg::DistMax : sum[snpzd_pkg::DistW-1:0];

  // A last chunk waits only when the result queue has no room.
  assign consume    = in_valid_i && (!in_last_i || !res_full_i);
  assign end_pair   = consume && in_last_i;
  assign in_pop_o   = consume;
  assign res_push_o = end_pair;
  assign res_dist_o = sat;

  always_comb begin
    acc_d = acc_q;
    if (end_pair) begin
      acc_d = '0;
    end else if (consume) begin
      acc_d = sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  `SNPZD_ASSERT_NEXT(a_back_clear, end_pair, acc_q == '0, "running distance not cleared after pair")
  `SNPZD_ASSERT_NEXT(a_back_mono, !end_pair, acc_q >= $past(acc_q), "running distance decreased within a pair")

endmodule
